@@ rtl/core/rcpf_pkg.sv @@
// ----------------------------------------------------------------------------
// Ray collinear point filter package
// Shared constants for the collinear point filter: default coordinate width,
// threshold register width and the threshold reset value.
// ----------------------------------------------------------------------------
package rcpf_pkg;

  localparam int COORD_BITS_DEF = 24;
  localparam int THRESH_W       = 32;

  // 0.001 in Q0.32.
  localparam logic [THRESH_W-1:0] THRESH_RESET = 32'd4294967;

endpackage

@@ rtl/core/ray_collinear_point_filter.sv @@
// ----------------------------------------------------------------------------
// Ray collinear point filter
// Removes lidar points whose step from the previous point of the row lies
// along the point's own ray, plus row starts and points after an all-zero
// point, with one shared multiplier and square root unit under a small sequencer.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Handshake             Payload
//  in_       slave      in_tvalid/in_tready   in_tdata {z, y, x}, in_tuser row_start
//  out_      master     out_tvalid/out_tready out_tdata {z, y, x}, out_tuser removed
//  cfg_      write      cfg_we                cfg_wdata collinear_threshold
//
// A tested point passes the multiply-accumulate steps, two bit-serial square
// roots giving COORD_BITS + 1 bit roots, the product of the roots and the
// difference before its result is loaded; a row start or a point after an
// all-zero point goes straight to loading. Reset is synchronous and active low;
// it sets the threshold to 0.001 and marks the previous point invalid. The result
// register lets the next point be accepted while a result waits on out_tready.
// ----------------------------------------------------------------------------
module ray_collinear_point_filter #(
  parameter int COORD_BITS = rcpf_pkg::COORD_BITS_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_tvalid,
  output logic                                  in_tready,
  // Bits from lowest: x_in, y_in, z_in, zero fill to whole bytes.
  input  logic [((3*COORD_BITS+7)/8)*8-1:0]     in_tdata,
  // Bit 0: row_start.
  input  logic                                  in_tuser,
  output logic                                  out_tvalid,
  input  logic                                  out_tready,
  // Bits from lowest: x_out, y_out, z_out, zero fill to whole bytes.
  output logic [((3*COORD_BITS+7)/8)*8-1:0]     out_tdata,
  // Bit 0: removed.
  output logic                                  out_tuser,
  input  logic                                  cfg_we,
  input  logic [rcpf_pkg::THRESH_W-1:0]         cfg_wdata
);

  localparam int CW     = COORD_BITS;
  localparam int TW     = ((3*CW+7)/8)*8;
  localparam int DW     = CW + 1;
  localparam int MW     = CW + 2;
  localparam int PW     = 2*CW + 4;
  localparam int SK     = CW + 1;
  localparam int SN     = 2*SK;
  localparam int SR     = SK + 2;
  localparam int CNT_W  = $clog2(SK);
  localparam int STEP_W = 3;
  localparam logic [CNT_W-1:0]  SQ_LAST  = CNT_W'(SK - 1);
  localparam logic [STEP_W-1:0] MAC_LAST = STEP_W'(6);

  typedef enum logic [2:0] {
    S_IDLE,
    S_MAC,
    S_SQD,
    S_SQP,
    S_PMUL,
    S_DIFF,
    S_DONE
  } state_t;

  state_t state_r;

  logic [rcpf_pkg::THRESH_W-1:0] thresh_r;
  logic signed [CW-1:0] last_x_r, last_y_r;
  logic                 last_valid_r;
  logic signed [CW-1:0] x_r, y_r, z_r;
  logic signed [DW-1:0] dx_r, dy_r;
  logic                 removed_r;
  logic [STEP_W-1:0]    step_r;
  logic signed [PW-1:0] prod_r, acc_r, dot_r;
  logic [SN-1:0]        sq_n_r, np2_r;
  logic [SR-1:0]        rem_r;
  logic [SK-1:0]        root_r, sd_r;
  logic [CNT_W-1:0]     cnt_r;
  logic [PW-1:0]        diff_r;
  logic                 out_valid_r;
  logic signed [CW-1:0] out_x_r, out_y_r, out_z_r;
  logic                 out_removed_r;

  logic signed [CW-1:0] in_x, in_y, in_z;
  logic                 in_acc;
  logic signed [MW-1:0] mul_a, mul_b;
  logic signed [PW-1:0] mul_p, mac_sum, dot_abs;
  logic [SR+1:0]        sq_shift, sq_trial;
  logic                 sq_ge;
  logic [SR-1:0]        rem_nxt;
  logic [SK-1:0]        root_nxt;
  logic                 keep;

  assign in_x   = in_tdata[CW-1:0];
  assign in_y   = in_tdata[2*CW-1:CW];
  assign in_z   = in_tdata[3*CW-1:2*CW];
  assign in_tready = (state_r == S_IDLE);
  assign in_acc    = in_tvalid && in_tready;

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    if (state_r == S_PMUL) begin
      mul_a = MW'({1'b0, sd_r});
      mul_b = MW'({1'b0, root_r});
    end else begin
      unique case (step_r)
        3'd0: begin mul_a = MW'(dx_r); mul_b = MW'(x_r); end
        3'd1: begin mul_a = MW'(dy_r); mul_b = MW'(y_r); end
        3'd2: begin mul_a = MW'(dx_r); mul_b = MW'(dx_r); end
        3'd3: begin mul_a = MW'(dy_r); mul_b = MW'(dy_r); end
        3'd4: begin mul_a = MW'(x_r);  mul_b = MW'(x_r); end
        3'd5: begin mul_a = MW'(y_r);  mul_b = MW'(y_r); end
        default: begin mul_a = '0; mul_b = '0; end
      endcase
    end
  end

  assign mul_p   = PW'(mul_a) * PW'(mul_b);
  assign mac_sum = acc_r + prod_r;
  assign dot_abs = dot_r[PW-1] ? -dot_r : dot_r;

  assign sq_shift = {rem_r, sq_n_r[SN-1 -: 2]};
  assign sq_trial = (SR+2)'({root_r, 2'b01});
  assign sq_ge    = (sq_shift >= sq_trial);
  assign rem_nxt  = sq_ge ? SR'(sq_shift - sq_trial) : SR'(sq_shift);
  assign root_nxt = {root_r[SK-2:0], sq_ge};

  assign keep = !removed_r && (diff_r >= PW'(thresh_r));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      thresh_r      <= rcpf_pkg::THRESH_RESET;
      last_x_r      <= '0;
      last_y_r      <= '0;
      last_valid_r  <= 1'b0;
      out_valid_r   <= 1'b0;
      step_r        <= '0;
      cnt_r         <= '0;
    end else begin
      if (cfg_we) begin
        thresh_r <= cfg_wdata;
      end
      if (out_valid_r && out_tready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_acc) begin
            x_r          <= in_x;
            y_r          <= in_y;
            z_r          <= in_z;
            dx_r         <= DW'(last_x_r) - DW'(in_x);
            dy_r         <= DW'(last_y_r) - DW'(in_y);
            last_x_r     <= in_x;
            last_y_r     <= in_y;
            last_valid_r <= |{in_x, in_y, in_z};
            step_r       <= '0;
            if (in_tuser || !last_valid_r) begin
              removed_r <= 1'b1;
              state_r   <= S_DONE;
            end else begin
              removed_r <= 1'b0;
              state_r   <= S_MAC;
            end
          end
        end
        S_MAC: begin
          prod_r <= mul_p;
          step_r <= step_r + 1'b1;
          unique case (step_r)
            3'd1, 3'd3, 3'd5: acc_r <= prod_r;
            3'd2: dot_r <= mac_sum;
            3'd4: sq_n_r <= mac_sum[SN-1:0];
            default: begin end
          endcase
          if (step_r == MAC_LAST) begin
            np2_r   <= mac_sum[SN-1:0];
            rem_r   <= '0;
            root_r  <= '0;
            cnt_r   <= '0;
            state_r <= S_SQD;
          end
        end
        S_SQD: begin
          rem_r  <= rem_nxt;
          root_r <= root_nxt;
          sq_n_r <= {sq_n_r[SN-3:0], 2'b00};
          cnt_r  <= cnt_r + 1'b1;
          if (cnt_r == SQ_LAST) begin
            sd_r    <= root_nxt;
            sq_n_r  <= np2_r;
            rem_r   <= '0;
            root_r  <= '0;
            cnt_r   <= '0;
            state_r <= S_SQP;
          end
        end
        S_SQP: begin
          rem_r  <= rem_nxt;
          root_r <= root_nxt;
          sq_n_r <= {sq_n_r[SN-3:0], 2'b00};
          cnt_r  <= cnt_r + 1'b1;
          if (cnt_r == SQ_LAST) begin
            state_r <= S_PMUL;
          end
        end
        S_PMUL: begin
          prod_r  <= mul_p;
          state_r <= S_DIFF;
        end
        S_DIFF: begin
          diff_r  <= (dot_abs >= prod_r) ? PW'(dot_abs - prod_r) : PW'(prod_r - dot_abs);
          state_r <= S_DONE;
        end
        S_DONE: begin
          if (!out_valid_r || out_tready) begin
            out_valid_r   <= 1'b1;
            out_x_r       <= keep ? x_r : '0;
            out_y_r       <= keep ? y_r : '0;
            out_z_r       <= keep ? z_r : '0;
            out_removed_r <= !keep;
            state_r       <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = TW'({out_z_r, out_y_r, out_x_r});
  assign out_tuser  = out_removed_r;

`ifndef SYNTHESIS
  a_removed_is_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tdata == '0)
    else $error("Removed point carries nonzero coordinates.");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("Input accepted again while a point is in progress.");

  a_row_start_removed: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && in_tuser |=> state_r == S_DONE && removed_r)
    else $error("Row start point was not marked for removal.");

  a_last_valid: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> last_valid_r == ($past(in_tdata[3*CW-1:0]) != '0))
    else $error("Previous point validity does not follow the accepted point.");
`endif

endmodule
